FILE: rtl/tolgq_pkg.sv
// Shared types, codes and defaults for the timestamp-ordered lock grant queue.
package tolgq_pkg;

  localparam int NODES_DEF      = 16;
  localparam int STAMP_BITS_DEF = 32;
  localparam int ACTION_W       = 2;
  localparam int STAMP_IN_W     = 32;
  localparam int SENDER_W       = 4;
  localparam int ACCEPT_W       = 16;
  localparam int FAULT_W        = 2;

  localparam logic [ACTION_W-1:0] ACT_REQUEST = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ACCEPT  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

  localparam logic [FAULT_W-1:0] FAULT_NONE    = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_EMPTY   = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0]   action;
    logic [STAMP_IN_W-1:0] stamp;
    logic [SENDER_W-1:0]   sender;
  } tolgq_in_t;

  typedef struct packed {
    logic                  grant_valid;
    logic [SENDER_W-1:0]   grant_to;
    logic [STAMP_IN_W-1:0] grant_stamp;
    logic [ACCEPT_W-1:0]   accept_total;
    logic [FAULT_W-1:0]    fault;
  } tolgq_out_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } tolgq_tbl_cmd_t;

endpackage

FILE: rtl/tolgq_table.sv
// Request table: entry memory with registered read and per-slot used bits.
module tolgq_table import tolgq_pkg::*; #(
  parameter int NODES      = NODES_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF,
  localparam int IDX_W     = (NODES > 1) ? $clog2(NODES) : 1,
  localparam int WORD_W    = STAMP_BITS + SENDER_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tolgq_tbl_cmd_t    cmd_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  input  logic [IDX_W-1:0]  wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i,
  input  logic [IDX_W-1:0]  clr_addr_i,
  output logic [WORD_W-1:0] rd_data_o,
  output logic              rd_used_o
);

  logic [WORD_W-1:0] mem [NODES];
  logic [NODES-1:0]  used_q;
  logic              rd_used_q;
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      rd_used_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        used_q[wr_addr_i] <= 1'b1;
      end
      if (cmd_i.clr_en) begin
        used_q[clr_addr_i] <= 1'b0;
      end
      if (cmd_i.rd_en) begin
        rd_used_q <= used_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_used_o = rd_used_q;

endmodule

FILE: rtl/timestamp_ordered_lock_grant_queue_core.sv
// Top level of the timestamp-ordered lock grant queue: sequencer, head search, output register.
//
// Input channel in_*: one lock message per transaction (action, stamp, sender),
// accepted when in_valid_i is high and in_stall_o is low. Output channel out_*:
// exactly one result per message, held in an output register until taken
// (out_valid_o high and out_stall_i low).
// Request and release messages scan the request table one slot per cycle
// through a single memory read port and separate (stamp, sender) comparators
// for the head and the second head; such a message passes through the scan
// state and then the final state before its result is registered. Accept and
// unknown messages go straight to the final state. in_stall_o is high
// while a message is in work, and low again as soon as its result is loaded,
// so the next message may be accepted while that result waits.
// If the receiver stalls and the output register is still full when the next
// result is ready, the block holds that result and keeps in_stall_o high.
// Reset clears the table's used bits, the logical clock, the accept count and
// the output valid bit; the block is ready in the first cycle after reset.
module timestamp_ordered_lock_grant_queue_core import tolgq_pkg::*; #(
  parameter int NODES      = NODES_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  tolgq_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output tolgq_out_t out_data_o
);

  localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int WORD_W = STAMP_BITS + SENDER_W;
  localparam int EXT_W  = (STAMP_BITS > STAMP_IN_W) ? STAMP_BITS : STAMP_IN_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  function automatic logic beats(input logic [STAMP_BITS-1:0] cs,
                                 input logic [SENDER_W-1:0]   cn,
                                 input logic [STAMP_BITS-1:0] bs,
                                 input logic [SENDER_W-1:0]   bn);
    return (cs < bs) || ((cs == bs) && (cn < bn));
  endfunction

  logic [1:0]            state_q, state_d;
  logic [ACTION_W-1:0]   act_q;
  logic [STAMP_BITS-1:0] stamp_q;
  logic [SENDER_W-1:0]   sender_q;
  logic [STAMP_BITS-1:0] clock_q, clock_d;
  logic [ACCEPT_W-1:0]   accept_q, accept_d;

  logic [IDX_W-1:0]      idx_q;
  logic                  issue_done_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_idx_q;

  logic                  h1_vld_q;
  logic [STAMP_BITS-1:0] h1_stamp_q;
  logic [SENDER_W-1:0]   h1_snd_q;
  logic                  h2_vld_q;
  logic [STAMP_BITS-1:0] h2_stamp_q;
  logic [SENDER_W-1:0]   h2_snd_q;
  logic                  free_vld_q;
  logic [IDX_W-1:0]      free_idx_q;

  logic                  out_valid_q;
  tolgq_out_t            out_q, res;

  tolgq_tbl_cmd_t        tbl_cmd;
  logic [WORD_W-1:0]     rd_data;
  logic                  rd_used;
  logic [STAMP_BITS-1:0] ent_stamp;
  logic [SENDER_W-1:0]   ent_snd;

  logic [EXT_W-1:0]      in_stamp_ext, clk_ext;
  logic [STAMP_BITS-1:0] in_stamp;
  logic                  in_acc, fin_go, scan_last;
  logic                  grant;
  logic [SENDER_W-1:0]   grant_to;
  logic [STAMP_BITS-1:0] clock_inc;

  assign in_stamp_ext = EXT_W'(in_data_i.stamp);
  assign in_stamp     = in_stamp_ext[STAMP_BITS-1:0];
  assign in_acc       = in_valid_i && !in_stall_o;
  assign in_stall_o   = (state_q != ST_IDLE);
  assign fin_go       = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign scan_last    = rd_vld_q && (rd_idx_q == LAST_IDX);

  assign ent_stamp = rd_data[WORD_W-1:SENDER_W];
  assign ent_snd   = rd_data[SENDER_W-1:0];

  assign tbl_cmd.rd_en  = (state_q == ST_SCAN) && !issue_done_q;
  assign tbl_cmd.wr_en  = fin_go && (act_q == ACT_REQUEST) && free_vld_q;
  assign tbl_cmd.clr_en = (state_q == ST_SCAN) && rd_vld_q && rd_used &&
                          (act_q == ACT_RELEASE) && (ent_snd == sender_q);

  tolgq_table #(
    .NODES      (NODES),
    .STAMP_BITS (STAMP_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (tbl_cmd),
    .rd_addr_i  (idx_q),
    .wr_addr_i  (free_idx_q),
    .wr_data_i  ({stamp_q, sender_q}),
    .clr_addr_i (rd_idx_q),
    .rd_data_o  (rd_data),
    .rd_used_o  (rd_used)
  );

  assign clock_inc = (clock_q == '1) ? clock_q : clock_q + 1'b1;

  always_comb begin
    grant    = 1'b0;
    grant_to = sender_q;
    res      = '0;
    accept_d = accept_q;
    res.fault = FAULT_NONE;
    case (act_q)
      ACT_REQUEST: begin
        if (h1_vld_q) begin
          grant = (h1_snd_q == sender_q) ||
                  (free_vld_q && beats(stamp_q, sender_q, h1_stamp_q, h1_snd_q));
        end else begin
          grant = free_vld_q;
        end
      end
      ACT_ACCEPT: begin
        if (accept_q != '1) begin
          accept_d = accept_q + 1'b1;
        end
      end
      ACT_RELEASE: begin
        if (!h1_vld_q) begin
          res.fault = FAULT_EMPTY;
        end else begin
          grant    = (h1_snd_q == sender_q) && h2_vld_q;
          grant_to = h2_snd_q;
        end
      end
      default: begin
        res.fault = FAULT_UNKNOWN;
      end
    endcase
    clock_d = grant ? clock_inc : clock_q;
    clk_ext = EXT_W'(clock_d);
    res.accept_total = accept_d;
    if (grant) begin
      res.grant_valid = 1'b1;
      res.grant_to    = grant_to;
      res.grant_stamp = clk_ext[STAMP_IN_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if ((in_data_i.action == ACT_REQUEST) || (in_data_i.action == ACT_RELEASE)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      clock_q      <= '0;
      accept_q     <= '0;
      out_valid_q  <= 1'b0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      idx_q        <= '0;
      h1_vld_q     <= 1'b0;
      h2_vld_q     <= 1'b0;
      free_vld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= tbl_cmd.rd_en;
      if (out_valid_q && !out_stall_i && !fin_go) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        if (in_stamp > clock_q) begin
          clock_q <= in_stamp;
        end
        idx_q        <= '0;
        issue_done_q <= 1'b0;
        h1_vld_q     <= 1'b0;
        h2_vld_q     <= 1'b0;
        free_vld_q   <= 1'b0;
      end
      if (tbl_cmd.rd_en) begin
        idx_q <= idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          issue_done_q <= 1'b1;
        end
      end
      if ((state_q == ST_SCAN) && rd_vld_q) begin
        if (!rd_used && !free_vld_q) begin
          free_vld_q <= 1'b1;
        end
        if (rd_used && (!h1_vld_q || beats(ent_stamp, ent_snd, h1_stamp_q, h1_snd_q))) begin
          h1_vld_q <= 1'b1;
        end
        if (rd_used && (ent_snd != sender_q) &&
            (!h2_vld_q || beats(ent_stamp, ent_snd, h2_stamp_q, h2_snd_q))) begin
          h2_vld_q <= 1'b1;
        end
      end
      if (fin_go) begin
        clock_q     <= clock_d;
        accept_q    <= accept_d;
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q    <= in_data_i.action;
      stamp_q  <= in_stamp;
      sender_q <= in_data_i.sender;
    end
    if (tbl_cmd.rd_en) begin
      rd_idx_q <= idx_q;
    end
    if ((state_q == ST_SCAN) && rd_vld_q) begin
      if (!rd_used && !free_vld_q) begin
        free_idx_q <= rd_idx_q;
      end
      if (rd_used && (!h1_vld_q || beats(ent_stamp, ent_snd, h1_stamp_q, h1_snd_q))) begin
        h1_stamp_q <= ent_stamp;
        h1_snd_q   <= ent_snd;
      end
      if (rd_used && (ent_snd != sender_q) &&
          (!h2_vld_q || beats(ent_stamp, ent_snd, h2_stamp_q, h2_snd_q))) begin
        h2_stamp_q <= ent_stamp;
        h2_snd_q   <= ent_snd;
      end
    end
    if (fin_go) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fault_no_grant : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.fault != FAULT_NONE) |-> !out_data_o.grant_valid)
    else $error("fault reported together with a grant");

  a_idle_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.grant_valid |->
      (out_data_o.grant_to == '0) && (out_data_o.grant_stamp == '0))
    else $error("grant fields nonzero without a grant");

  a_accept_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> accept_q >= $past(accept_q))
    else $error("accept count decreased");

  a_read_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == ST_SCAN)
    else $error("table read data outside of a scan");

endmodule
